>>> hw/rtl/fdt_pkg.sv
// ----------------------------------------------------------------------------
// fdt_pkg
// Shared constants, types and helper functions for the fixed-point to
// decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package fdt_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int INT_BITS     = 32;
  localparam int MAX_DECIMALS = 4;

  localparam int VALUE_W = INT_BITS + FRAC_BITS;
  localparam int DECF_W  = 3;   // width of the decimals field
  localparam int CHAR_W  = 8;
  localparam int POW_MAX = 20;  // 10^19 is the largest that fits 64 bits

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // character select codes
  localparam logic [1:0] CHSEL_DIGIT = 2'd0;
  localparam logic [1:0] CHSEL_DOT   = 2'd1;
  localparam logic [1:0] CHSEL_MINUS = 2'd2;

  function automatic longint unsigned pow10_of(int unsigned n);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < POW_MAX; i++) begin
      if (i < n) p = p * 64'd10;
    end
    return p;
  endfunction

  function automatic int num_digits(longint unsigned v);
    int n;
    n = 1;
    for (int i = 1; i < POW_MAX; i++) begin
      if (v >= pow10_of(i)) n = i + 1;
    end
    return n;
  endfunction

  localparam int INT_DIGITS = num_digits(longint'(64'd1 << (INT_BITS - 1)));
  localparam int P10_W      = $clog2(pow10_of(MAX_DECIMALS) + 64'd1);
  localparam int PROD_W     = FRAC_BITS + P10_W;
  localparam int RF_W       = P10_W + 1;
  localparam int REM_W      = (INT_BITS > P10_W) ? INT_BITS : P10_W;
  localparam int MUL_W      = REM_W + 4;
  localparam int K_W        = $clog2((INT_DIGITS > MAX_DECIMALS) ? INT_DIGITS : MAX_DECIMALS);
  localparam int DEC_W      = $clog2(MAX_DECIMALS + 1);

  // c * 10^k, constant table selected by the digit position
  function automatic logic [MUL_W-1:0] dig_mult(logic [K_W-1:0] k, logic [3:0] c);
    longint unsigned p;
    p = pow10_of(int'(k));
    return MUL_W'(p * longint'(c));
  endfunction

  typedef struct packed {
    logic       load;       // capture the input beat
    logic       mag;        // sign and magnitude
    logic       mul;        // fraction times 10^decimals
    logic       rnd;        // round, split whole and fraction
    logic       lead;       // find leading digit, load whole part
    logic       step;       // peel one digit off the remainder
    logic       load_frac;  // load fraction digits
    logic       emit;       // write the output register
    logic [1:0] chsel;
    logic       last;
  } fdt_cmd_t;

  typedef struct packed {
    logic neg;
    logic dec_zero;
    logic k_zero;
    logic out_free;
  } fdt_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/fdt_if.sv
// ----------------------------------------------------------------------------
// fdt_if
// Valid/ready channels: number input and character output.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdt_in_if
  import fdt_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic        [DECF_W-1:0]  decimals;

  modport source (output valid, output value, output decimals, input ready);
  modport sink   (input valid, input value, input decimals, output ready);
endinterface

interface fdt_out_if
  import fdt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fdt_ctrl.sv
// ----------------------------------------------------------------------------
// fdt_ctrl
// Sequencer: setup steps, then one character per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_ctrl
  import fdt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire fdt_stat_t stat,
  output fdt_cmd_t       cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MAG  = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_RND  = 4'd3;
  localparam logic [3:0] ST_LEAD = 4'd4;
  localparam logic [3:0] ST_SIGN = 4'd5;
  localparam logic [3:0] ST_INT  = 4'd6;
  localparam logic [3:0] ST_DOT  = 4'd7;
  localparam logic [3:0] ST_FRAC = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.chsel = CHSEL_DIGIT;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MAG;
        end
      end
      ST_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_LEAD;
      end
      ST_LEAD: begin
        cmd.lead  = 1'b1;
        state_nxt = stat.neg ? ST_SIGN : ST_INT;
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.chsel = CHSEL_MINUS;
          state_nxt = ST_INT;
        end
      end
      ST_INT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.step = 1'b1;
          cmd.last = stat.k_zero && stat.dec_zero;
          if (stat.k_zero) state_nxt = stat.dec_zero ? ST_IDLE : ST_DOT;
        end
      end
      ST_DOT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.chsel     = CHSEL_DOT;
          cmd.load_frac = 1'b1;
          state_nxt     = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.step = 1'b1;
          cmd.last = stat.k_zero;
          if (stat.k_zero) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/fdt_datapath.sv
// ----------------------------------------------------------------------------
// fdt_datapath
// Magnitude, rounding, digit extraction and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_datapath
  import fdt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic        [DECF_W-1:0]  in_decimals,
  input  wire fdt_cmd_t                  cmd,
  output fdt_stat_t                      stat,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic             [CHAR_W-1:0]  out_text_char,
  output logic                           out_last
);

  logic [VALUE_W-1:0]  raw_r;
  logic [DEC_W-1:0]    dec_r;
  logic                neg_r;
  logic [VALUE_W-1:0]  mag_r;
  logic [PROD_W-1:0]   prod_r;
  logic [INT_BITS-1:0] whole_r;
  logic [P10_W-1:0]    frac_r;
  logic [REM_W-1:0]    rem_r;
  logic [K_W-1:0]      k_r;
  logic [CHAR_W-1:0]   char_r;
  logic                last_r;
  logic                valid_r;

  logic [P10_W-1:0]    p10;
  logic [RF_W-1:0]     rf;
  logic                carry;
  logic [K_W-1:0]      lead;
  logic [3:0]          digit;
  logic [MUL_W-1:0]    rem_ext;
  logic [MUL_W-1:0]    sub;
  logic [CHAR_W-1:0]   char_sel;
  logic [DEC_W-1:0]    dec_sat;

  assign p10 = P10_W'(pow10_of(int'(dec_r)));
  assign dec_sat = (in_decimals > DECF_W'(MAX_DECIMALS)) ? DEC_W'(MAX_DECIMALS)
                                                        : in_decimals[DEC_W-1:0];

  // round half up: add half an LSB of the fraction scale
  assign rf    = RF_W'((PROD_W+1)'(prod_r) + (PROD_W+1)'(1 << (FRAC_BITS - 1)) >> FRAC_BITS);
  assign carry = (rf == RF_W'(p10));

  always_comb begin
    lead = '0;
    for (int k = 1; k < INT_DIGITS; k++) begin
      if (MUL_W'(whole_r) >= MUL_W'(pow10_of(k))) lead = K_W'(k);
    end
  end

  // digit = count of multiples of 10^k that fit in the remainder
  assign rem_ext = MUL_W'(rem_r);
  always_comb begin
    digit = '0;
    for (int c = 1; c < 10; c++) begin
      if (rem_ext >= dig_mult(k_r, 4'(c))) digit = 4'(c);
    end
    sub = dig_mult(k_r, digit);
  end

  always_comb begin
    unique case (cmd.chsel)
      CHSEL_DOT:   char_sel = CH_DOT;
      CHSEL_MINUS: char_sel = CH_MINUS;
      default:     char_sel = CH_ZERO + CHAR_W'(digit);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_r <= in_value;
      dec_r <= dec_sat;
    end
    if (cmd.mag) begin
      neg_r <= raw_r[VALUE_W-1];
      mag_r <= raw_r[VALUE_W-1] ? (~raw_r + VALUE_W'(1)) : raw_r;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mag_r[FRAC_BITS-1:0]) * PROD_W'(p10);
    end
    if (cmd.rnd) begin
      whole_r <= mag_r[VALUE_W-1:FRAC_BITS] + INT_BITS'(carry);
      frac_r  <= carry ? '0 : P10_W'(rf);
    end
    if (cmd.lead) begin
      rem_r <= REM_W'(whole_r);
      k_r   <= lead;
    end else if (cmd.load_frac) begin
      rem_r <= REM_W'(frac_r);
      k_r   <= K_W'(dec_r) - K_W'(1);
    end else if (cmd.step) begin
      rem_r <= rem_r - REM_W'(sub);
      k_r   <= k_r - K_W'(1);
    end
    if (cmd.emit) begin
      char_r <= char_sel;
      last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        valid_r <= 1'b0;
    else if (cmd.emit) valid_r <= 1'b1;
    else if (out_ready) valid_r <= 1'b0;
  end

  assign stat.neg      = neg_r;
  assign stat.dec_zero = (dec_r == '0);
  assign stat.k_zero   = (k_r == '0);
  assign stat.out_free = !valid_r || out_ready;

  assign out_valid     = valid_r;
  assign out_text_char = char_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

>>> hw/rtl/fixed_to_decimal_text.sv
// ----------------------------------------------------------------------------
// fixed_to_decimal_text
// Renders a signed Q31.16 number as decimal ASCII, one character per beat.
// ----------------------------------------------------------------------------
// The input beat is captured, then the setup chain (magnitude, fraction
// multiply, round, leading-digit search) runs before the first character is
// loaded. A text is 1..16 characters long. The extractor peels one digit a
// cycle while the output register is free to take it; a new number is taken
// only once the last character sits in the output register.
// Reset: synchronous, active low; clears the sequencer and the output valid.
`default_nettype none

module fixed_to_decimal_text
  import fdt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  fdt_in_if.sink    in_ch,
  fdt_out_if.source out_ch
);

  fdt_cmd_t  cmd;
  fdt_stat_t stat;

  // Controller: drives in_ch.ready (high only while idle) and walks the
  // sign, integer digits, dot and fraction digits in order.
  fdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: exact round-half-up at the chosen place. A carry out of the
  // fraction bumps the whole part; digits come out by compare against the
  // multiples of 10^k, most significant first. The output register lets the
  // next character load in the same cycle the current beat is taken.
  fdt_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_ch.value),
    .in_decimals   (in_ch.decimals),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_text_char (out_ch.text_char),
    .out_last      (out_ch.last)
  );

endmodule

`default_nettype wire
